// File: design/ibhq_pkg.sv
`timescale 1ns / 1ps
package ibhq_pkg;

  // Largest number of elements the heap holds; slot 0 is never used.
  localparam int unsigned CAPACITY   = 255;
  localparam int unsigned ID_W       = 8;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned SLOT_W     = 8;
  localparam int unsigned HEAP_DEPTH = CAPACITY + 1;
  localparam int unsigned ID_DEPTH   = 1 << ID_W;

  // Operation codes carried by an input item.
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_INVERT = 2'd2;
  localparam logic [1:0] MODE_QUERY  = 2'd3;

  // One heap slot: element id and its signed priority.
  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [VAL_W-1:0] val;
  } heap_entry_t;

  // Datapath commands, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SET_ERR,
    OP_UPD_RD,
    OP_NEW,
    OP_SU_RD,
    OP_SU_MOVE,
    OP_PLACE,
    OP_SD_RD,
    OP_SD_MOVE,
    OP_RM_RD,
    OP_RM_POP,
    OP_INV_START,
    OP_INV_RD,
    OP_INV_LD,
    OP_INV_NEXT,
    OP_FIN_RD,
    OP_FIN_RD2,
    OP_OUT
  } dp_op_t;

  // Datapath status flags seen by the controller.
  typedef struct packed {
    logic [1:0] mode;
    logic       valid_id;
    logic       slot_hit;
    logic       full;
    logic       empty;
    logic       count_gt1;
    logic       up_more;
    logic       up_move;
    logic       leaf;
    logic       dn_move;
    logic       upd_down;
    logic       inv_zero;
    logic       out_free;
  } dp_stat_t;

  // True when priority a belongs nearer the root than priority b.
  function automatic logic ahead(input logic lf, input logic signed [VAL_W-1:0] a,
                                 input logic signed [VAL_W-1:0] b);
    ahead = lf ? (a > b) : (a < b);
  endfunction

endpackage

// File: design/ibhq_datapath.sv
`timescale 1ns / 1ps
module ibhq_datapath
  import ibhq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  dp_op_t                  op,
  output dp_stat_t                stat,
  input  logic [1:0]              in_mode,
  input  logic [ID_W-1:0]         in_elem,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    cfg_wr_en,
  input  logic [ID_W-1:0]         cfg_wr_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    status,
  output logic [ID_W-1:0]         top_elem,
  output logic signed [VAL_W-1:0] top_value,
  output logic [SLOT_W-1:0]       count,
  output logic                    present,
  output logic signed [VAL_W-1:0] elem_value
);

  // Heap slots and element-to-slot map.
  heap_entry_t       hmem [HEAP_DEPTH];
  logic [SLOT_W-1:0] smem [ID_DEPTH];
  logic [ID_DEPTH-1:0] sval;

  heap_entry_t       rd_a, rd_b;
  logic [SLOT_W-1:0] sdata;

  // Control and working registers.
  logic [SLOT_W-1:0] item_count;
  logic              largest_first;
  logic [ID_W-1:0]   max_element;
  logic [1:0]        mode_r;
  logic [ID_W-1:0]   elem_r;
  logic              err;
  heap_entry_t       cur;
  logic [SLOT_W-1:0] pos;
  logic [SLOT_W-1:0] inv_idx;

  // Port controls.
  logic              hwe, sre, swe, are, bre;
  logic [SLOT_W-1:0] hwaddr, aaddr, baddr, swdata;
  logic [ID_W-1:0]   swaddr, sraddr;
  heap_entry_t       hwdata;

  // Child selection for sift down.
  logic [SLOT_W:0]   lchild, rchild;
  logic              c_right;
  heap_entry_t       child;
  logic [SLOT_W-1:0] c_pos;
  logic              valid_id;
  logic              here;

  assign lchild   = {pos, 1'b0};
  assign rchild   = {pos, 1'b1};
  assign c_right  = (rchild <= {1'b0, item_count}) && ahead(largest_first, rd_b.val, rd_a.val);
  assign child    = c_right ? rd_b : rd_a;
  assign c_pos    = c_right ? rchild[SLOT_W-1:0] : lchild[SLOT_W-1:0];
  assign valid_id = (elem_r != '0) && (elem_r <= max_element);
  assign here     = valid_id && sval[elem_r];

  // Status toward the controller.
  always_comb begin
    stat.mode      = mode_r;
    stat.valid_id  = valid_id;
    stat.slot_hit  = sval[elem_r];
    stat.full      = ({{(32-SLOT_W){1'b0}}, item_count} >= CAPACITY);
    stat.empty     = (item_count == '0);
    stat.count_gt1 = (item_count > SLOT_W'(1));
    stat.up_more   = (pos > SLOT_W'(1));
    stat.up_move   = ahead(largest_first, cur.val, rd_a.val);
    stat.leaf      = (lchild > {1'b0, item_count});
    stat.dn_move   = ahead(largest_first, child.val, cur.val);
    stat.upd_down  = ahead(largest_first, rd_a.val, cur.val);
    stat.inv_zero  = (inv_idx == '0);
    stat.out_free  = !out_valid || out_ready;
  end

  // Memory port decode.
  always_comb begin
    hwe    = 1'b0;
    hwaddr = pos;
    hwdata = cur;
    swe    = 1'b0;
    swaddr = cur.id;
    swdata = pos;
    sre    = 1'b0;
    sraddr = elem_r;
    are    = 1'b0;
    aaddr  = pos;
    bre    = 1'b0;
    baddr  = pos;
    unique case (op)
      OP_LOAD: begin
        sre    = 1'b1;
        sraddr = in_elem;
      end
      OP_UPD_RD: begin
        are   = 1'b1;
        aaddr = sdata;
      end
      OP_SU_RD: begin
        are   = 1'b1;
        aaddr = pos >> 1;
      end
      OP_SU_MOVE: begin
        hwe    = 1'b1;
        hwdata = rd_a;
        swe    = 1'b1;
        swaddr = rd_a.id;
      end
      OP_PLACE: begin
        hwe = 1'b1;
        swe = 1'b1;
      end
      OP_SD_RD: begin
        are   = 1'b1;
        aaddr = lchild[SLOT_W-1:0];
        bre   = 1'b1;
        baddr = rchild[SLOT_W-1:0];
      end
      OP_SD_MOVE: begin
        hwe    = 1'b1;
        hwdata = child;
        swe    = 1'b1;
        swaddr = child.id;
      end
      OP_RM_RD: begin
        are   = 1'b1;
        aaddr = SLOT_W'(1);
        bre   = 1'b1;
        baddr = item_count;
      end
      OP_INV_RD: begin
        are   = 1'b1;
        aaddr = inv_idx;
      end
      OP_FIN_RD: begin
        are   = 1'b1;
        aaddr = SLOT_W'(1);
        sre   = 1'b1;
      end
      OP_FIN_RD2: begin
        bre   = 1'b1;
        baddr = sdata;
      end
      default: begin
      end
    endcase
  end

  // Heap memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (hwe) begin
      hmem[hwaddr] <= hwdata;
    end
    if (are) begin
      rd_a <= hmem[aaddr];
    end
    if (bre) begin
      rd_b <= hmem[baddr];
    end
  end

  // Slot map memory with registered read.
  always_ff @(posedge clk) begin
    if (swe) begin
      smem[swaddr] <= swdata;
    end
    if (sre) begin
      sdata <= smem[sraddr];
    end
  end

  // Working registers, slot valid bits and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_count    <= '0;
      largest_first <= 1'b0;
      max_element   <= '1;
      sval          <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_element <= cfg_wr_data;
      end
      // A new result replaces the one taken in the same cycle.
      if (op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (swe) begin
        sval[swaddr] <= 1'b1;
      end
      unique case (op)
        OP_LOAD: begin
          mode_r  <= in_mode;
          elem_r  <= in_elem;
          cur.id  <= in_elem;
          cur.val <= in_value;
          err     <= 1'b0;
        end
        OP_SET_ERR: err <= 1'b1;
        OP_UPD_RD:  pos <= sdata;
        OP_NEW: begin
          item_count <= item_count + SLOT_W'(1);
          pos        <= item_count + SLOT_W'(1);
        end
        OP_SU_MOVE: pos <= pos >> 1;
        OP_SD_MOVE: pos <= c_pos;
        OP_RM_POP: begin
          sval[rd_a.id] <= 1'b0;
          item_count    <= item_count - SLOT_W'(1);
          cur           <= rd_b;
          pos           <= SLOT_W'(1);
        end
        OP_INV_START: begin
          largest_first <= !largest_first;
          inv_idx       <= item_count >> 1;
        end
        OP_INV_LD: begin
          cur <= rd_a;
          pos <= inv_idx;
        end
        OP_INV_NEXT: inv_idx <= inv_idx - SLOT_W'(1);
        OP_OUT: begin
          status     <= err;
          top_elem   <= (item_count != '0) ? rd_a.id : '0;
          top_value  <= (item_count != '0) ? rd_a.val : '0;
          count      <= item_count;
          present    <= here;
          elem_value <= here ? rd_b.val : '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: design/ibhq_ctrl.sv
`timescale 1ns / 1ps
module ibhq_ctrl
  import ibhq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_op_t   op
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_UPD_CMP,
    S_SU_CHK,
    S_SU_CMP,
    S_SD_CHK,
    S_SD_CMP,
    S_RM_POP,
    S_INV_CHK,
    S_INV_LD,
    S_INV_NEXT,
    S_FIN1,
    S_FIN2,
    S_FIN3
  } state_t;

  state_t state, state_next, done_state;

  // After a sift finishes, an invert moves to its next node.
  assign done_state = (stat.mode == MODE_INVERT) ? S_INV_NEXT : S_FIN1;

  // Command decode and next state.
  always_comb begin
    op         = OP_NONE;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.mode)
          MODE_INSERT: begin
            if (!stat.valid_id) begin
              op         = OP_SET_ERR;
              state_next = S_FIN1;
            end else if (stat.slot_hit) begin
              op         = OP_UPD_RD;
              state_next = S_UPD_CMP;
            end else if (stat.full) begin
              op         = OP_SET_ERR;
              state_next = S_FIN1;
            end else begin
              op         = OP_NEW;
              state_next = S_SU_CHK;
            end
          end
          MODE_REMOVE: begin
            if (stat.empty) begin
              op         = OP_SET_ERR;
              state_next = S_FIN1;
            end else begin
              op         = OP_RM_RD;
              state_next = S_RM_POP;
            end
          end
          MODE_INVERT: begin
            op         = OP_INV_START;
            state_next = S_INV_CHK;
          end
          MODE_QUERY: begin
            op         = stat.valid_id ? OP_NONE : OP_SET_ERR;
            state_next = S_FIN1;
          end
          default: state_next = S_FIN1;
        endcase
      end
      // An update that moves away from the root sifts down, otherwise up.
      S_UPD_CMP: state_next = stat.upd_down ? S_SD_CHK : S_SU_CHK;
      S_SU_CHK: begin
        if (stat.up_more) begin
          op         = OP_SU_RD;
          state_next = S_SU_CMP;
        end else begin
          op         = OP_PLACE;
          state_next = done_state;
        end
      end
      S_SU_CMP: begin
        if (stat.up_move) begin
          op         = OP_SU_MOVE;
          state_next = S_SU_CHK;
        end else begin
          op         = OP_PLACE;
          state_next = done_state;
        end
      end
      S_SD_CHK: begin
        if (stat.leaf) begin
          op         = OP_PLACE;
          state_next = done_state;
        end else begin
          op         = OP_SD_RD;
          state_next = S_SD_CMP;
        end
      end
      S_SD_CMP: begin
        if (stat.dn_move) begin
          op         = OP_SD_MOVE;
          state_next = S_SD_CHK;
        end else begin
          op         = OP_PLACE;
          state_next = done_state;
        end
      end
      S_RM_POP: begin
        op         = OP_RM_POP;
        state_next = stat.count_gt1 ? S_SD_CHK : S_FIN1;
      end
      S_INV_CHK: begin
        if (stat.inv_zero) begin
          state_next = S_FIN1;
        end else begin
          op         = OP_INV_RD;
          state_next = S_INV_LD;
        end
      end
      S_INV_LD: begin
        op         = OP_INV_LD;
        state_next = S_SD_CHK;
      end
      S_INV_NEXT: begin
        op         = OP_INV_NEXT;
        state_next = S_INV_CHK;
      end
      S_FIN1: begin
        op         = OP_FIN_RD;
        state_next = S_FIN2;
      end
      S_FIN2: begin
        op         = OP_FIN_RD2;
        state_next = S_FIN3;
      end
      S_FIN3: begin
        if (stat.out_free) begin
          op         = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: design/indexed_binary_heap_queue.sv
`timescale 1ns / 1ps
// Each item runs to completion: a query, bad id or empty remove goes straight to the result;
// insert and update sift up or down one heap level at a time, and remove sifts down from the root.
// Invert runs a sift down from every inner node, from the last one back to the root.
// One item is in work at a time: a new one is taken only back in idle; a waiting result holds the input.
// Synchronous reset empties the heap at once (slot map valid bits cleared), selects
// smallest-first order and sets max_element to 255.
module indexed_binary_heap_queue
  import ibhq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [ID_W-1:0]         cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              mode,
  input  logic [ID_W-1:0]         elem,
  input  logic signed [VAL_W-1:0] value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    status,
  output logic [ID_W-1:0]         top_elem,
  output logic signed [VAL_W-1:0] top_value,
  output logic [SLOT_W-1:0]       count,
  output logic                    present,
  output logic signed [VAL_W-1:0] elem_value
);

  dp_op_t   op;
  dp_stat_t stat;

  // Sequencer for the sift, remove and invert walks.
  ibhq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .op       (op)
  );

  // Heap memories, slot map and result register.
  ibhq_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .stat        (stat),
    .in_mode     (mode),
    .in_elem     (elem),
    .in_value    (value),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .top_elem    (top_elem),
    .top_value   (top_value),
    .count       (count),
    .present     (present),
    .elem_value  (elem_value)
  );

endmodule

// File: tb/sv/indexed_binary_heap_queue_test.sv
`timescale 1ns / 1ps
module indexed_binary_heap_queue_test;
  import ibhq_pkg::*;

  // One expected answer of the queue.
  typedef struct packed {
    logic                    status;
    logic [ID_W-1:0]         top_elem;
    logic signed [VAL_W-1:0] top_value;
    logic [SLOT_W-1:0]       count;
    logic                    present;
    logic signed [VAL_W-1:0] elem_value;
  } answer_t;

  // Scoreboard: keeps a shadow heap and the answers still owed by the block.
  class heap_scoreboard;
    logic [ID_W-1:0]         ids[256];
    logic signed [VAL_W-1:0] vals[256];
    int unsigned             slot_of[256];
    int unsigned             held;
    bit                      largest_first;
    int unsigned             max_id;
    answer_t                 owed[$];
    int unsigned             mismatches;

    function new();
      foreach (ids[i]) begin
        ids[i] = '0;
        vals[i] = '0;
        slot_of[i] = 0;
      end
      held = 0;
      largest_first = 0;
      max_id = 255;
      mismatches = 0;
    endfunction

    function bit better(logic signed [VAL_W-1:0] a, logic signed [VAL_W-1:0] b);
      return largest_first ? (a > b) : (a < b);
    endfunction

    function void put(int unsigned pos, logic [ID_W-1:0] id, logic signed [VAL_W-1:0] v);
      ids[pos] = id;
      vals[pos] = v;
      slot_of[id] = pos;
    endfunction

    function void bubble_up(int unsigned pos);
      logic [ID_W-1:0]         id;
      logic signed [VAL_W-1:0] v;
      id = ids[pos];
      v = vals[pos];
      while (pos > 1 && better(v, vals[pos/2])) begin
        put(pos, ids[pos/2], vals[pos/2]);
        pos = pos / 2;
      end
      put(pos, id, v);
    endfunction

    function void bubble_down(int unsigned pos);
      logic [ID_W-1:0]         id;
      logic signed [VAL_W-1:0] v;
      int unsigned             c;
      if (pos * 2 > held) return;
      id = ids[pos];
      v = vals[pos];
      while (pos * 2 <= held) begin
        c = pos * 2;
        if (c + 1 <= held && better(vals[c+1], vals[c])) c++;
        if (!better(vals[c], v)) break;
        put(pos, ids[c], vals[c]);
        pos = c;
      end
      put(pos, id, v);
    endfunction

    // Apply one accepted item to the shadow heap and record the answer it owes.
    function void note_item(logic [1:0] md, logic [ID_W-1:0] el, logic signed [VAL_W-1:0] v);
      answer_t                 a;
      bit                      ok_id;
      int unsigned             pos;
      logic signed [VAL_W-1:0] old;
      ok_id = (el >= 1 && el <= max_id);
      a.status = 0;
      case (md)
        MODE_INSERT: begin
          if (!ok_id) a.status = 1;
          else if (slot_of[el] != 0) begin
            pos = slot_of[el];
            old = vals[pos];
            vals[pos] = v;
            if (better(old, v)) bubble_down(pos);
            else if (better(v, old)) bubble_up(pos);
          end else if (held >= CAPACITY) a.status = 1;
          else begin
            held++;
            put(held, el, v);
            bubble_up(held);
          end
        end
        MODE_REMOVE: begin
          if (held == 0) a.status = 1;
          else begin
            slot_of[ids[1]] = 0;
            if (held > 1) put(1, ids[held], vals[held]);
            ids[held] = '0;
            vals[held] = '0;
            held--;
            if (held > 1) bubble_down(1);
          end
        end
        MODE_INVERT: begin
          largest_first = !largest_first;
          for (int i = held / 2; i > 0; i--) bubble_down(i);
        end
        default: if (!ok_id) a.status = 1;
      endcase
      a.top_elem = held ? ids[1] : '0;
      a.top_value = held ? vals[1] : '0;
      a.count = held[7:0];
      a.present = ok_id && slot_of[el] != 0;
      a.elem_value = a.present ? vals[slot_of[el]] : '0;
      owed.push_back(a);
    endfunction

    // Compare one result from the block with the oldest owed answer.
    function void check_answer(answer_t got);
      answer_t e;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result item at %0t", $realtime);
        return;
      end
      e = owed.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: exp st=%0d top=%0d/%0d cnt=%0d pr=%0d ev=%0d, got st=%0d top=%0d/%0d cnt=%0d pr=%0d ev=%0d",
                   e.status, e.top_elem, e.top_value, e.count, e.present, e.elem_value,
                   got.status, got.top_elem, got.top_value, got.count, got.present,
                   got.elem_value);
      end
    endfunction
  endclass

  logic                    clk = 0;
  logic                    rst = 1;
  logic                    cfg_wr_en = 0;
  logic [ID_W-1:0]         cfg_wr_data = '0;
  logic                    in_valid = 0;
  logic                    in_ready;
  logic [1:0]              mode = MODE_QUERY;
  logic [ID_W-1:0]         elem = '0;
  logic signed [VAL_W-1:0] value = '0;
  logic                    out_valid;
  logic                    out_ready = 0;
  logic                    status;
  logic [ID_W-1:0]         top_elem;
  logic signed [VAL_W-1:0] top_value;
  logic [SLOT_W-1:0]       count;
  logic                    present;
  logic signed [VAL_W-1:0] elem_value;

  heap_scoreboard board = new();
  longint unsigned cycles = 0;
  bit stim_done = 0;

  indexed_binary_heap_queue i_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .elem(elem), .value(value),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .top_elem(top_elem),
    .top_value(top_value), .count(count), .present(present), .elem_value(elem_value)
  );

  always #10 clk = ~clk;

  // Note accepted items and check results at the rising edge.
  always @(posedge clk) begin
    answer_t got;
    cycles <= cycles + 1;
    if (!rst && in_valid && in_ready) board.note_item(mode, elem, value);
    if (!rst && out_valid && out_ready) begin
      got.status = status;
      got.top_elem = top_elem;
      got.top_value = top_value;
      got.count = count;
      got.present = present;
      got.elem_value = elem_value;
      board.check_answer(got);
    end
  end

  // The result side stalls at random, with calm stretches in between.
  initial begin
    int gap;
    @(negedge clk);
    while (1) begin
      gap = ($urandom_range(0, 7) < 2) ? 0 : $urandom_range(0, 3);
      out_ready <= 0;
      repeat (gap) @(negedge clk);
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Offer one item and hold it until accepted; valid drops only during an idle gap.
  task automatic send_item(logic [1:0] md, logic [ID_W-1:0] el, logic signed [VAL_W-1:0] v);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    mode <= md;
    elem <= el;
    value <= v;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Wait for all answers, then write the bound register.
  task automatic set_max_id(logic [ID_W-1:0] m);
    in_valid <= 0;
    while (board.owed.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_wr_data <= m;
    cfg_wr_en <= 1;
    @(negedge clk);
    cfg_wr_en <= 0;
    board.max_id = m;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(0, 6)) - 3);
      default: return $signed($urandom());
    endcase
  endfunction

  // Random phase: mostly inserts and removals, some queries and inverts.
  task automatic random_phase(int n, int id_span);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) send_item(MODE_INSERT, 8'($urandom_range(0, id_span)), pick_value());
      else if (r < 72) send_item(MODE_REMOVE, 8'($urandom()), $signed($urandom()));
      else if (r < 76) send_item(MODE_INVERT, 8'($urandom()), $signed($urandom()));
      else if (r < 96)
        send_item(MODE_QUERY, 8'($urandom_range(0, id_span)), $signed($urandom()));
      else send_item(2'($urandom()), 8'($urandom()), $signed($urandom()));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // Directed: empty remove, bad ids, extremes, equal priorities, invert.
    send_item(MODE_REMOVE, 8'd0, '0);
    send_item(MODE_INVERT, 8'd0, '0);
    send_item(MODE_INVERT, 8'd0, '0);
    send_item(MODE_INSERT, 8'd0, 32'sd5);
    send_item(MODE_QUERY, 8'd0, '0);
    send_item(MODE_INSERT, 8'd255, 32'sh7fffffff);
    send_item(MODE_INSERT, 8'd1, 32'sh80000000);
    send_item(MODE_INSERT, 8'd2, 32'sd7);
    send_item(MODE_INSERT, 8'd3, 32'sd7);
    send_item(MODE_QUERY, 8'd255, '0);
    send_item(MODE_INSERT, 8'd2, 32'sh80000000);
    send_item(MODE_INSERT, 8'd1, 32'sh7fffffff);
    send_item(MODE_INVERT, 8'd0, '0);
    send_item(MODE_QUERY, 8'd3, '0);
    send_item(MODE_REMOVE, 8'd0, '0);
    send_item(MODE_INVERT, 8'd0, '0);
    send_item(MODE_REMOVE, 8'd0, '0);
    // Lowered bound: held ids above it become bad ids but stay removable.
    set_max_id(8'd2);
    send_item(MODE_QUERY, 8'd3, '0);
    send_item(MODE_INSERT, 8'd3, 32'sd1);
    send_item(MODE_INSERT, 8'd2, 32'sd1);
    send_item(MODE_REMOVE, 8'd0, '0);
    send_item(MODE_REMOVE, 8'd0, '0);
    send_item(MODE_REMOVE, 8'd0, '0);
    send_item(MODE_REMOVE, 8'd0, '0);
    set_max_id(8'd1);
    random_phase(60, 3);
    set_max_id(8'd20);
    random_phase(300, 24);
    // Fill to capacity to reach the full-heap case.
    set_max_id(8'd255);
    for (int i = 1; i <= 255; i++) send_item(MODE_INSERT, i[7:0], pick_value());
    send_item(MODE_INSERT, 8'd9, 32'sd0);
    send_item(MODE_INVERT, 8'd0, '0);
    random_phase(600, 255);
    set_max_id(8'd128);
    random_phase(100, 255);
    in_valid <= 0;
    stim_done = 1;
  end

  // End of run or timeout.
  initial begin
    wait (stim_done);
    while (board.owed.size() != 0 && cycles < 2000000) @(negedge clk);
    repeat (50) @(negedge clk);
    if (board.owed.size() == 0 && board.mismatches == 0 && cycles < 2000000)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    wait (cycles >= 2500000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
